>>> hdl/bbd_pkg.sv
// Shared types and constants for the bilinear Bayer demosaic.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bbd_pkg;

	// Sample positions inside one packed column (upper in the low bits).
	localparam int ROW_UP = 0;
	localparam int ROW_CE = 1;
	localparam int ROW_LO = 2;
	localparam int ROWS   = 3;

	// Number of columns of the current line held in the window.
	typedef enum logic [1:0] {
		HELD_NONE = 2'd0,
		HELD_ONE  = 2'd1,
		HELD_TWO  = 2'd2
	} held_t;

	// Per-pixel flags carried with a job from front to back.
	typedef struct packed {
		logic rodd;   // centre row is odd
		logic codd;   // centre column is odd
		logic last;   // last pixel of the line
	} job_flags_t;

endpackage

>>> hdl/bayer_bilinear_demosaic.sv
// Top level of the bilinear Bayer demosaic (BGGR phase, mirrored line ends).
// Depends on bbd_pkg, bbd_fifo, bbd_front and bbd_back.
//
//  channel   | handshake        | beat contents
//  ----------+------------------+-------------------------------------------------
//  columns   | push / full      | upper/centre/lower_sample, row_is_odd, line_end
//  pixels    | pop / empty      | red_out, green_out, blue_out, last_of_line
//
// One column beat is taken per clock while full is low. After a line_end column
// that follows another column of the same line, full rises and stays high while
// the front posts the extra mirrored pixel into the job queue.
// A pixel is registered in the job queue and then in the result queue on its way
// to the result side; the extra mirrored pixel of a line end trails behind it.
// Either side may stall: the job queue and the result queue absorb it, and full
// follows the job queue. Asynchronous reset clears window state and both queues.
`timescale 1ns / 1ps

module bayer_bilinear_demosaic
	import bbd_pkg::*;
#(
	parameter int SAMPLE_BITS = 8,
	parameter int JOB_DEPTH   = 4,
	parameter int OUT_DEPTH   = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [SAMPLE_BITS-1:0] upper_sample,
	input  logic [SAMPLE_BITS-1:0] centre_sample,
	input  logic [SAMPLE_BITS-1:0] lower_sample,
	input  logic                   row_is_odd,
	input  logic                   line_end,
	input  logic                   pop,
	output logic                   empty,
	output logic [SAMPLE_BITS-1:0] red_out,
	output logic [SAMPLE_BITS-1:0] green_out,
	output logic [SAMPLE_BITS-1:0] blue_out,
	output logic                   last_of_line
);

	localparam int COL_W = ROWS * SAMPLE_BITS;
	localparam int JOB_W = 3 * COL_W + $bits(job_flags_t);

	// packed column: upper in the low bits, lower in the high bits
	logic [COL_W-1:0] col;
	assign col = {lower_sample, centre_sample, upper_sample};

	// front -> job queue
	logic             jq_push;
	logic             jq_full;
	logic [JOB_W-1:0] jq_wdata;

	// job queue -> back
	logic             jq_pop;
	logic             jq_empty;
	logic [JOB_W-1:0] jq_rdata;

	// Front: sliding window, left mirroring and line-end bookkeeping.
	bbd_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.col       (col),
		.row_is_odd(row_is_odd),
		.line_end  (line_end),
		.job_push  (jq_push),
		.job_full  (jq_full),
		.job_data  (jq_wdata)
	);

	// Decoupling queue: each job carries the three columns plus pixel flags.
	bbd_fifo #(
		.WIDTH(JOB_W),
		.DEPTH(JOB_DEPTH)
	) u_job_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (jq_push),
		.full  (jq_full),
		.wdata (jq_wdata),
		.pop   (jq_pop),
		.empty (jq_empty),
		.rdata (jq_rdata)
	);

	// Back: interpolation and result queue.
	bbd_back #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.OUT_DEPTH  (OUT_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_empty   (jq_empty),
		.job_pop     (jq_pop),
		.job_data    (jq_rdata),
		.pop         (pop),
		.empty       (empty),
		.red_out     (red_out),
		.green_out   (green_out),
		.blue_out    (blue_out),
		.last_of_line(last_of_line)
	);

endmodule

>>> hdl/bbd_fifo.sv
// Small register queue with push/full and pop/empty handshakes.
// Depends on bbd_pkg only for house consistency (no types used beyond imports).
`timescale 1ns / 1ps

module bbd_fifo
	import bbd_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fifo count beyond depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("fifo count did not grow on push");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("fifo count did not shrink on pop");

endmodule

>>> hdl/bbd_front.sv
// Front end: accepts columns, keeps the three-column window and posts pixel jobs.
// Depends on bbd_pkg (held_t, job_flags_t).
`timescale 1ns / 1ps

module bbd_front
	import bbd_pkg::*;
#(
	parameter int SAMPLE_BITS = 8
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     push,
	output logic                                     full,
	input  logic [ROWS*SAMPLE_BITS-1:0]              col,
	input  logic                                     row_is_odd,
	input  logic                                     line_end,
	output logic                                     job_push,
	input  logic                                     job_full,
	output logic [3*ROWS*SAMPLE_BITS+$bits(job_flags_t)-1:0] job_data
);

	localparam int COL_W = ROWS * SAMPLE_BITS;
	localparam int JOB_W = 3 * COL_W + $bits(job_flags_t);

	logic [COL_W-1:0] left_q;
	logic [COL_W-1:0] mid_q;
	held_t            held_q;
	logic             mid_codd_q;
	logic             mid_rodd_q;
	logic             pend_q;
	logic [JOB_W-1:0] pend_job_q;

	logic             accept;
	logic             now_valid;
	logic [COL_W-1:0] lc_sel;
	job_flags_t       now_flags;
	job_flags_t       pend_flags;
	logic [JOB_W-1:0] job_now;

	assign full   = pend_q || job_full;
	assign accept = push && !full;

	always_comb begin
		lc_sel     = (held_q == HELD_ONE) ? col : left_q;
		pend_flags = '{rodd: row_is_odd, codd: ~mid_codd_q, last: 1'b1};
		if (held_q == HELD_NONE) begin
			// lone column line: it is its own neighbor on both sides
			now_flags = '{rodd: row_is_odd, codd: 1'b0, last: 1'b1};
			job_now   = {now_flags, col, col, col};
			now_valid = accept && line_end;
		end else begin
			now_flags = '{rodd: mid_rodd_q, codd: mid_codd_q, last: 1'b0};
			job_now   = {now_flags, col, mid_q, lc_sel};
			now_valid = accept;
		end
		job_push = pend_q ? !job_full : now_valid;
		job_data = pend_q ? pend_job_q : job_now;
	end

	// mirrored right edge: the last column's right neighbor is its left one
	always_ff @(posedge clk) begin
		if (accept && line_end && held_q != HELD_NONE) begin
			pend_job_q <= {pend_flags, mid_q, col, mid_q};
		end
		if (accept && !(held_q == HELD_NONE && line_end)) begin
			mid_q <= col;
			if (held_q != HELD_NONE) begin
				left_q <= mid_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= HELD_NONE;
			mid_codd_q <= 1'b0;
			mid_rodd_q <= 1'b0;
			pend_q     <= 1'b0;
		end else begin
			if (pend_q && !job_full) begin
				pend_q <= 1'b0;
			end
			if (accept) begin
				if (line_end) begin
					held_q     <= HELD_NONE;
					mid_codd_q <= 1'b0;
					mid_rodd_q <= 1'b0;
					pend_q     <= (held_q != HELD_NONE);
				end else if (held_q == HELD_NONE) begin
					held_q     <= HELD_ONE;
					mid_codd_q <= 1'b0;
					mid_rodd_q <= row_is_odd;
				end else begin
					held_q     <= HELD_TWO;
					mid_codd_q <= ~mid_codd_q;
					mid_rodd_q <= row_is_odd;
				end
			end
		end
	end

	a_pend_set: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && line_end && held_q != HELD_NONE) |=> pend_q)
		else $error("line end pixel not queued");

	a_line_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && line_end) |=> (held_q == HELD_NONE && !mid_codd_q))
		else $error("window not cleared at line end");

	a_pend_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !accept)
		else $error("column taken while line end pixel pending");

endmodule

>>> hdl/bbd_back.sv
// Back end: takes pixel jobs, forms the bilinear RGB and queues the results.
// Depends on bbd_pkg (job_flags_t, row constants) and bbd_fifo.
`timescale 1ns / 1ps

module bbd_back
	import bbd_pkg::*;
#(
	parameter int SAMPLE_BITS = 8,
	parameter int OUT_DEPTH   = 2
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             job_empty,
	output logic                                             job_pop,
	input  logic [3*ROWS*SAMPLE_BITS+$bits(job_flags_t)-1:0] job_data,
	input  logic                                             pop,
	output logic                                             empty,
	output logic [SAMPLE_BITS-1:0]                           red_out,
	output logic [SAMPLE_BITS-1:0]                           green_out,
	output logic [SAMPLE_BITS-1:0]                           blue_out,
	output logic                                             last_of_line
);

	localparam int SB    = SAMPLE_BITS;
	localparam int COL_W = ROWS * SB;
	localparam int RES_W = 3 * SB + 1;

	logic [COL_W-1:0] lc, mc, rc;
	job_flags_t       flags;
	logic [SB:0]      horiz2, vert2;
	logic [SB+1:0]    cross4, diag4;
	logic [SB-1:0]    r, g, b;
	logic             out_full;
	logic [RES_W-1:0] res_in, res_out;

	always_comb begin
		lc    = job_data[0 +: COL_W];
		mc    = job_data[COL_W +: COL_W];
		rc    = job_data[2*COL_W +: COL_W];
		flags = job_data[3*COL_W +: $bits(job_flags_t)];

		horiz2 = {1'b0, lc[ROW_CE*SB +: SB]} + {1'b0, rc[ROW_CE*SB +: SB]};
		vert2  = {1'b0, mc[ROW_UP*SB +: SB]} + {1'b0, mc[ROW_LO*SB +: SB]};
		cross4 = {1'b0, vert2} + {1'b0, horiz2};
		diag4  = {2'b00, lc[ROW_UP*SB +: SB]} + {2'b00, rc[ROW_UP*SB +: SB]}
		       + {2'b00, lc[ROW_LO*SB +: SB]} + {2'b00, rc[ROW_LO*SB +: SB]};

		case ({flags.rodd, flags.codd})
			2'b11: begin    // red site
				r = mc[ROW_CE*SB +: SB];
				g = cross4[SB+1:2];
				b = diag4[SB+1:2];
			end
			2'b00: begin    // blue site
				r = diag4[SB+1:2];
				g = cross4[SB+1:2];
				b = mc[ROW_CE*SB +: SB];
			end
			2'b01: begin    // green on a blue row
				g = mc[ROW_CE*SB +: SB];
				b = horiz2[SB:1];
				r = vert2[SB:1];
			end
			default: begin  // green on a red row
				g = mc[ROW_CE*SB +: SB];
				r = horiz2[SB:1];
				b = vert2[SB:1];
			end
		endcase
	end

	assign job_pop = !job_empty && !out_full;
	assign res_in  = {flags.last, b, g, r};

	bbd_fifo #(
		.WIDTH(RES_W),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (job_pop),
		.full  (out_full),
		.wdata (res_in),
		.pop   (pop),
		.empty (empty),
		.rdata (res_out)
	);

	assign red_out      = res_out[0 +: SB];
	assign green_out    = res_out[SB +: SB];
	assign blue_out     = res_out[2*SB +: SB];
	assign last_of_line = res_out[3*SB];

endmodule
